// ----- rtl/core/rot3d_pkg.sv -----
package rot3d_pkg;

    // Default build values.
    localparam int FRACTION_BITS_DEF = 16;
    localparam int CORDIC_STEPS_DEF  = 24;

    // Fixed formats of the rotation math.
    localparam logic signed [33:0] ONE_Q30      = 34'sd1073741824;
    localparam logic signed [33:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic signed [63:0] DEG_TO_RAD_Q32 = 64'sd74961321;

    // Stage counts of the axis path and the rotation stage.
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;
    localparam int AX_LAT     = 5 + SQRT_STEPS + DIV_STEPS + 1;
    localparam int ROT_LAT    = 7;

    // Unit axis handed to the rotation stage.
    typedef struct packed {
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic signed [31:0] uz;
        logic               zero;
    } axis_t;

    // Cosine and sine in Q2.30.
    typedef struct packed {
        logic signed [31:0] cos_v;
        logic signed [31:0] sin_v;
    } cs_t;

    // One result item.
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               zero;
        logic               sat;
    } res_t;

    // CORDIC angle table, round(atan(2^-i) * 2^30).
    function automatic logic [31:0] atan_q30(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'd843314857;
            1: v = 32'd497837829;
            2: v = 32'd263043837;
            3: v = 32'd133525159;
            4: v = 32'd67021687;
            5: v = 32'd33543516;
            6: v = 32'd16775851;
            7: v = 32'd8388437;
            8: v = 32'd4194283;
            9: v = 32'd2097149;
            10: v = 32'd1048576;
            11: v = 32'd524288;
            12: v = 32'd262144;
            13: v = 32'd131072;
            14: v = 32'd65536;
            15: v = 32'd32768;
            16: v = 32'd16384;
            17: v = 32'd8192;
            18: v = 32'd4096;
            19: v = 32'd2048;
            20: v = 32'd1024;
            21: v = 32'd512;
            22: v = 32'd256;
            23: v = 32'd128;
            24: v = 32'd64;
            25: v = 32'd32;
            26: v = 32'd16;
            27: v = 32'd8;
            28: v = 32'd4;
            29: v = 32'd2;
            30: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

    // Smallest s with (360 << fb) << s at least 2^31.
    function automatic int mod_shift(input int fb);
        int s;
        int i;
        s = 0;
        for (i = 0; i < 32; i++) begin
            if ((longint'(360) << (fb + s)) < (longint'(1) << 31)) begin
                s = s + 1;
            end
        end
        return s;
    endfunction

    // Depth of the sine and cosine path.
    function automatic int sc_latency(input int fb, input int steps);
        return mod_shift(fb) + 1 + steps + 6;
    endfunction

endpackage

// ----- rtl/core/rot3d_delay.sv -----
module rot3d_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    generate
        if (DEPTH == 0) begin : g_none
            assign dout = din;
        end else begin : g_line
            logic [WIDTH-1:0] tap_reg [DEPTH];

            // Shift line that moves only when the pipeline advances.
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    tap_reg[0] <= din;
                    for (int i = 1; i < DEPTH; i++)
                    begin
                        tap_reg[i] <= tap_reg[i-1];
                    end
                end
            end

            assign dout = tap_reg[DEPTH-1];
        end
    endgenerate

endmodule

// ----- rtl/core/rot3d_axis_norm.sv -----
module rot3d_axis_norm (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [31:0]    axis_x,
    input  logic signed [31:0]    axis_y,
    input  logic signed [31:0]    axis_z,
    input  logic                  axis_present,
    output rot3d_pkg::axis_t      axis
);

    localparam int SQ = rot3d_pkg::SQRT_STEPS;
    localparam int DV = rot3d_pkg::DIV_STEPS;

    typedef struct packed {
        logic [2:0][31:0] am;
        logic [2:0]       neg;
        logic             pres;
        logic             zero;
    } side_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       pres;
        logic       zero;
    } flag_t;

    logic [31:0] mag_a_reg [3];
    logic [2:0]  neg_a_reg;
    logic        pres_a_reg;
    logic [31:0] max_a_reg;

    logic [31:0] mag_b_reg [3];
    logic [2:0]  neg_b_reg;
    logic        pres_b_reg;
    logic        zero_b_reg;
    logic [4:0]  sh_b_reg;

    side_t       side_c_reg;
    side_t       side_d_reg;
    side_t       side_e_reg;
    logic [63:0] sq_d_reg [3];
    logic [63:0] sum_e_reg;

    logic [63:0] sq_n_reg [SQ];
    logic [35:0] sq_rem_reg [SQ];
    logic [33:0] sq_root_reg [SQ];
    logic [63:0] sq_n_next [SQ];
    logic [35:0] sq_rem_next [SQ];
    logic [33:0] sq_root_next [SQ];

    logic [31:0] dv_len_reg [DV];
    logic [33:0] dv_rem_reg [DV][3];
    logic [30:0] dv_q_reg [DV][3];
    logic [31:0] dv_len_next [DV];
    logic [33:0] dv_rem_next [DV][3];
    logic [30:0] dv_q_next [DV][3];

    side_t       side_sq;
    flag_t       flag_in;
    flag_t       flag_dv;
    rot3d_pkg::axis_t axis_reg;
    rot3d_pkg::axis_t axis_next;

    logic [31:0] mag_in [3];
    logic [31:0] max_in;
    logic [4:0]  msb_b;
    logic        pow2_b;
    logic [4:0]  sh_next;

    // Magnitudes and the largest one.
    always_comb
    begin
        mag_in[0] = axis_x[31] ? 32'(-axis_x) : 32'(axis_x);
        mag_in[1] = axis_y[31] ? 32'(-axis_y) : 32'(axis_y);
        mag_in[2] = axis_z[31] ? 32'(-axis_z) : 32'(axis_z);
        max_in = mag_in[0];
        if (mag_in[1] > max_in) max_in = mag_in[1];
        if (mag_in[2] > max_in) max_in = mag_in[2];
    end

    // Normalizing shift: largest s with max << s no more than 2^31.
    always_comb
    begin
        msb_b = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (max_a_reg[i]) msb_b = 5'(i);
        end
        pow2_b = ((max_a_reg & (max_a_reg - 32'd1)) == 32'd0);
        if (max_a_reg == 32'd0) sh_next = 5'd0;
        else if (pow2_b) sh_next = 5'd31 - msb_b;
        else sh_next = 5'd30 - msb_b;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                mag_a_reg[k] <= mag_in[k];
                mag_b_reg[k] <= mag_a_reg[k];
                side_c_reg.am[k] <= mag_b_reg[k] << sh_b_reg;
                sq_d_reg[k] <= 64'(side_c_reg.am[k]) * 64'(side_c_reg.am[k]);
            end
            neg_a_reg  <= {axis_z[31], axis_y[31], axis_x[31]};
            pres_a_reg <= axis_present;
            max_a_reg  <= max_in;
            neg_b_reg  <= neg_a_reg;
            pres_b_reg <= pres_a_reg;
            zero_b_reg <= pres_a_reg && (max_a_reg == 32'd0);
            sh_b_reg   <= sh_next;
            side_c_reg.neg  <= neg_b_reg;
            side_c_reg.pres <= pres_b_reg;
            side_c_reg.zero <= zero_b_reg;
            side_d_reg <= side_c_reg;
            side_e_reg <= side_d_reg;
            sum_e_reg  <= sq_d_reg[0] + sq_d_reg[1] + sq_d_reg[2];
        end
    end

    // Square root, one result bit per stage.
    always_comb
    begin
        logic [63:0] n_in;
        logic [35:0] rem_in;
        logic [33:0] root_in;
        logic [35:0] rem2;
        logic [35:0] trial;
        for (int j = 0; j < SQ; j++)
        begin
            if (j == 0)
            begin
                n_in    = sum_e_reg;
                rem_in  = 36'd0;
                root_in = 34'd0;
            end
            else
            begin
                n_in    = sq_n_reg[j-1];
                rem_in  = sq_rem_reg[j-1];
                root_in = sq_root_reg[j-1];
            end
            rem2  = {rem_in[33:0], n_in[63:62]};
            trial = {root_in, 2'b01};
            sq_n_next[j] = n_in << 2;
            if (rem2 >= trial)
            begin
                sq_rem_next[j]  = rem2 - trial;
                sq_root_next[j] = {root_in[32:0], 1'b1};
            end
            else
            begin
                sq_rem_next[j]  = rem2;
                sq_root_next[j] = {root_in[32:0], 1'b0};
            end
        end
    end

    rot3d_delay #(.WIDTH($bits(side_t)), .DEPTH(SQ)) u_sq_side (
        .clk  (clk),
        .en   (en),
        .din  (side_e_reg),
        .dout (side_sq)
    );

    // Restoring divide of the scaled components by the length.
    always_comb
    begin
        logic [33:0] r_in;
        logic [31:0] len_in;
        logic        ge;
        for (int j = 0; j < DV; j++)
        begin
            len_in = (j == 0) ? sq_root_reg[SQ-1][31:0] : dv_len_reg[j-1];
            dv_len_next[j] = len_in;
            for (int k = 0; k < 3; k++)
            begin
                if (j == 0) r_in = 34'(side_sq.am[k]);
                else r_in = {dv_rem_reg[j-1][k][32:0], 1'b0};
                ge = (r_in >= 34'(len_in));
                dv_rem_next[j][k] = ge ? r_in - 34'(len_in) : r_in;
                if (j == 0) dv_q_next[j][k] = 31'(ge);
                else dv_q_next[j][k] = {dv_q_reg[j-1][k][29:0], ge};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int j = 0; j < SQ; j++)
            begin
                sq_n_reg[j]    <= sq_n_next[j];
                sq_rem_reg[j]  <= sq_rem_next[j];
                sq_root_reg[j] <= sq_root_next[j];
            end
            for (int j = 0; j < DV; j++)
            begin
                dv_len_reg[j] <= dv_len_next[j];
                for (int k = 0; k < 3; k++)
                begin
                    dv_rem_reg[j][k] <= dv_rem_next[j][k];
                    dv_q_reg[j][k]   <= dv_q_next[j][k];
                end
            end
            axis_reg <= axis_next;
        end
    end

    assign flag_in = '{neg: side_sq.neg, pres: side_sq.pres, zero: side_sq.zero};

    rot3d_delay #(.WIDTH($bits(flag_t)), .DEPTH(DV)) u_dv_side (
        .clk  (clk),
        .en   (en),
        .din  (flag_in),
        .dout (flag_dv)
    );

    // Signs back on, or the default axis when none is given.
    always_comb
    begin
        logic signed [31:0] uq [3];
        for (int k = 0; k < 3; k++)
        begin
            uq[k] = flag_dv.neg[k] ? -$signed(32'(dv_q_reg[DV-1][k]))
                                   : $signed(32'(dv_q_reg[DV-1][k]));
        end
        if (flag_dv.pres)
        begin
            axis_next.ux = uq[0];
            axis_next.uy = uq[1];
            axis_next.uz = uq[2];
        end
        else
        begin
            axis_next.ux = 32'sd0;
            axis_next.uy = 32'sd0;
            axis_next.uz = 32'(rot3d_pkg::ONE_Q30);
        end
        axis_next.zero = flag_dv.zero;
    end

    assign axis = axis_reg;

endmodule

// ----- rtl/core/rot3d_sincos.sv -----
module rot3d_sincos #(
    parameter int FRACTION_BITS = rot3d_pkg::FRACTION_BITS_DEF,
    parameter int CORDIC_STEPS  = rot3d_pkg::CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] angle_deg,
    output rot3d_pkg::cs_t     cs
);

    localparam int     KS   = rot3d_pkg::mod_shift(FRACTION_BITS);
    localparam int     NQ   = KS + 1;
    localparam int     N    = CORDIC_STEPS;
    localparam longint FULL = longint'(360) << FRACTION_BITS;
    localparam logic signed [34:0] FULL_V    = 35'(FULL);
    localparam logic signed [34:0] HALF_V    = 35'(FULL >> 1);
    localparam logic signed [34:0] QUARTER_V = 35'(FULL >> 2);
    localparam logic [34:0]        OFFSET    = 35'(FULL << KS);

    logic [34:0]        v_reg;
    logic [34:0]        md_reg [NQ];
    logic [34:0]        md_next [NQ];
    logic signed [34:0] f1_reg;
    logic signed [34:0] f2_reg;
    logic signed [34:0] f2_next;
    logic               f2_flip_reg;
    logic               f2_flip_next;
    logic signed [63:0] prod_reg;
    logic               mul_flip_reg;
    logic signed [33:0] z_reg;
    logic signed [33:0] z_next;
    logic               z_flip_reg;
    logic signed [33:0] cx_reg [N];
    logic signed [33:0] cy_reg [N];
    logic signed [33:0] cz_reg [N];
    logic signed [33:0] cx_next [N];
    logic signed [33:0] cy_next [N];
    logic signed [33:0] cz_next [N];
    logic               flip_d;
    rot3d_pkg::cs_t     cs_reg;
    rot3d_pkg::cs_t     cs_next;

    // Modulo of the offset angle, one quotient bit per stage.
    always_comb
    begin
        logic [34:0] src;
        logic [34:0] step_v;
        for (int j = 0; j < NQ; j++)
        begin
            src    = (j == 0) ? v_reg : md_reg[j-1];
            step_v = 35'(FULL << (NQ - 1 - j));
            md_next[j] = (src >= step_v) ? src - step_v : src;
        end
    end

    // Fold to [-90, 90] degrees with a sign flip.
    always_comb
    begin
        f2_next      = f1_reg;
        f2_flip_next = 1'b0;
        if (f1_reg > QUARTER_V)
        begin
            f2_next      = f1_reg - HALF_V;
            f2_flip_next = 1'b1;
        end
        else if (f1_reg < -QUARTER_V)
        begin
            f2_next      = f1_reg + HALF_V;
            f2_flip_next = 1'b1;
        end
    end

    // Radians in Q2.30, rounded half away from zero.
    always_comb
    begin
        logic [63:0] mag;
        logic [63:0] m;
        mag = prod_reg[63] ? 64'(-prod_reg) : 64'(prod_reg);
        m = (mag + (64'd1 << (FRACTION_BITS + 1))) >> (FRACTION_BITS + 2);
        z_next = prod_reg[63] ? -$signed(34'(m)) : $signed(34'(m));
    end

    // CORDIC rotation, one iteration per stage.
    always_comb
    begin
        logic signed [33:0] xi;
        logic signed [33:0] yi;
        logic signed [33:0] zi;
        logic signed [33:0] at;
        for (int j = 0; j < N; j++)
        begin
            if (j == 0)
            begin
                xi = rot3d_pkg::INV_GAIN_Q30;
                yi = 34'sd0;
                zi = z_reg;
            end
            else
            begin
                xi = cx_reg[j-1];
                yi = cy_reg[j-1];
                zi = cz_reg[j-1];
            end
            at = $signed(34'(rot3d_pkg::atan_q30(j)));
            if (!zi[33])
            begin
                cx_next[j] = xi - (yi >>> j);
                cy_next[j] = yi + (xi >>> j);
                cz_next[j] = zi - at;
            end
            else
            begin
                cx_next[j] = xi + (yi >>> j);
                cy_next[j] = yi - (xi >>> j);
                cz_next[j] = zi + at;
            end
        end
    end

    // Clip to one and undo the fold.
    always_comb
    begin
        logic signed [33:0] xc;
        logic signed [33:0] yc;
        xc = cx_reg[N-1];
        yc = cy_reg[N-1];
        if (xc > rot3d_pkg::ONE_Q30) xc = rot3d_pkg::ONE_Q30;
        if (xc < -rot3d_pkg::ONE_Q30) xc = -rot3d_pkg::ONE_Q30;
        if (yc > rot3d_pkg::ONE_Q30) yc = rot3d_pkg::ONE_Q30;
        if (yc < -rot3d_pkg::ONE_Q30) yc = -rot3d_pkg::ONE_Q30;
        cs_next.cos_v = flip_d ? -32'(xc) : 32'(xc);
        cs_next.sin_v = flip_d ? -32'(yc) : 32'(yc);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            v_reg <= 35'(angle_deg) + OFFSET;
            for (int j = 0; j < NQ; j++)
            begin
                md_reg[j] <= md_next[j];
            end
            f1_reg <= ($signed(md_reg[NQ-1]) >= HALF_V) ? $signed(md_reg[NQ-1]) - FULL_V
                                                        : $signed(md_reg[NQ-1]);
            f2_reg       <= f2_next;
            f2_flip_reg  <= f2_flip_next;
            prod_reg     <= 64'(f2_reg) * rot3d_pkg::DEG_TO_RAD_Q32;
            mul_flip_reg <= f2_flip_reg;
            z_reg        <= z_next;
            z_flip_reg   <= mul_flip_reg;
            for (int j = 0; j < N; j++)
            begin
                cx_reg[j] <= cx_next[j];
                cy_reg[j] <= cy_next[j];
                cz_reg[j] <= cz_next[j];
            end
            cs_reg <= cs_next;
        end
    end

    rot3d_delay #(.WIDTH(1), .DEPTH(N)) u_flip (
        .clk  (clk),
        .en   (en),
        .din  (z_flip_reg),
        .dout (flip_d)
    );

    assign cs = cs_reg;

endmodule

// ----- rtl/core/rot3d_rotate.sv -----
module rot3d_rotate (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] point [3],
    input  logic signed [31:0] anchor [3],
    input  rot3d_pkg::axis_t   axis,
    input  rot3d_pkg::cs_t     cs,
    output rot3d_pkg::res_t    res
);

    localparam logic signed [41:0] MAX_V = 42'sd2147483647;
    localparam logic signed [41:0] MIN_V = -42'sd2147483648;

    typedef struct packed {
        logic [2:0][31:0] p;
        logic [2:0][31:0] anc;
        logic             zero;
    } side_t;

    // Product over 2^30, rounded half away from zero.
    function automatic logic signed [41:0] rnd30(input logic signed [79:0] v);
        logic [79:0] mag;
        logic [79:0] m;
        mag = v[79] ? 80'(-v) : 80'(v);
        m = (mag + (80'd1 << 29)) >> 30;
        return v[79] ? -$signed(42'(m)) : $signed(42'(m));
    endfunction

    logic signed [32:0] d_r1 [3];
    logic signed [31:0] u_r1 [3];
    logic signed [31:0] c_r1;
    logic signed [31:0] s_r1;

    logic signed [79:0] prd_r2 [9];
    logic signed [32:0] d_r2 [3];
    logic signed [31:0] u_r2 [3];
    logic signed [31:0] c_r2;
    logic signed [31:0] s_r2;

    logic signed [41:0] dot_r3;
    logic signed [41:0] cr_r3 [3];
    logic signed [32:0] d_r3 [3];
    logic signed [31:0] u_r3 [3];
    logic signed [31:0] c_r3;
    logic signed [31:0] s_r3;

    logic signed [79:0] pq_r4 [3];
    logic signed [79:0] pdc_r4 [3];
    logic signed [79:0] pcs_r4 [3];
    logic signed [31:0] c_r4;

    logic signed [41:0] q_r5 [3];
    logic signed [41:0] dc_r5 [3];
    logic signed [41:0] crs_r5 [3];
    logic signed [31:0] c_r5;

    logic signed [79:0] pqc_r6 [3];
    logic signed [41:0] q_r6 [3];
    logic signed [41:0] dc_r6 [3];
    logic signed [41:0] crs_r6 [3];

    side_t              side_in;
    side_t              side_d;
    rot3d_pkg::res_t    res_reg;
    rot3d_pkg::res_t    res_next;

    assign side_in.p    = {point[2], point[1], point[0]};
    assign side_in.anc  = {anchor[2], anchor[1], anchor[0]};
    assign side_in.zero = axis.zero;

    rot3d_delay #(.WIDTH($bits(side_t)), .DEPTH(rot3d_pkg::ROT_LAT - 1)) u_side (
        .clk  (clk),
        .en   (en),
        .din  (side_in),
        .dout (side_d)
    );

    // Sum the rotated terms, add the pivot back and clip.
    always_comb
    begin
        logic signed [41:0] r;
        logic signed [31:0] o [3];
        logic               sat;
        sat = 1'b0;
        for (int k = 0; k < 3; k++)
        begin
            r = q_r6[k] - rnd30(pqc_r6[k]) + dc_r6[k] + crs_r6[k]
                + 42'($signed(side_d.anc[k]));
            if (r > MAX_V)
            begin
                o[k] = MAX_V[31:0];
                sat = 1'b1;
            end
            else if (r < MIN_V)
            begin
                o[k] = MIN_V[31:0];
                sat = 1'b1;
            end
            else
            begin
                o[k] = r[31:0];
            end
        end
        if (side_d.zero)
        begin
            res_next.x    = side_d.p[0];
            res_next.y    = side_d.p[1];
            res_next.z    = side_d.p[2];
            res_next.zero = 1'b1;
            res_next.sat  = 1'b0;
        end
        else
        begin
            res_next.x    = o[0];
            res_next.y    = o[1];
            res_next.z    = o[2];
            res_next.zero = 1'b0;
            res_next.sat  = sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // Offset from the pivot and the coefficients.
            for (int k = 0; k < 3; k++)
            begin
                d_r1[k] <= 33'(point[k]) - 33'(anchor[k]);
            end
            u_r1[0] <= axis.ux;
            u_r1[1] <= axis.uy;
            u_r1[2] <= axis.uz;
            c_r1    <= cs.cos_v;
            s_r1    <= cs.sin_v;

            // Dot and cross products.
            prd_r2[0] <= 80'(d_r1[0]) * 80'(u_r1[0]);
            prd_r2[1] <= 80'(d_r1[1]) * 80'(u_r1[1]);
            prd_r2[2] <= 80'(d_r1[2]) * 80'(u_r1[2]);
            prd_r2[3] <= 80'(d_r1[2]) * 80'(u_r1[1]);
            prd_r2[4] <= 80'(d_r1[1]) * 80'(u_r1[2]);
            prd_r2[5] <= 80'(d_r1[0]) * 80'(u_r1[2]);
            prd_r2[6] <= 80'(d_r1[2]) * 80'(u_r1[0]);
            prd_r2[7] <= 80'(d_r1[1]) * 80'(u_r1[0]);
            prd_r2[8] <= 80'(d_r1[0]) * 80'(u_r1[1]);
            d_r2 <= d_r1;
            u_r2 <= u_r1;
            c_r2 <= c_r1;
            s_r2 <= s_r1;

            dot_r3   <= rnd30(prd_r2[0]) + rnd30(prd_r2[1]) + rnd30(prd_r2[2]);
            cr_r3[0] <= rnd30(prd_r2[3]) - rnd30(prd_r2[4]);
            cr_r3[1] <= rnd30(prd_r2[5]) - rnd30(prd_r2[6]);
            cr_r3[2] <= rnd30(prd_r2[7]) - rnd30(prd_r2[8]);
            d_r3 <= d_r2;
            u_r3 <= u_r2;
            c_r3 <= c_r2;
            s_r3 <= s_r2;

            // Projection, cosine and sine terms.
            for (int k = 0; k < 3; k++)
            begin
                pq_r4[k]  <= 80'(dot_r3) * 80'(u_r3[k]);
                pdc_r4[k] <= 80'(d_r3[k]) * 80'(c_r3);
                pcs_r4[k] <= 80'(cr_r3[k]) * 80'(s_r3);
                q_r5[k]   <= rnd30(pq_r4[k]);
                dc_r5[k]  <= rnd30(pdc_r4[k]);
                crs_r5[k] <= rnd30(pcs_r4[k]);
                pqc_r6[k] <= 80'(q_r5[k]) * 80'(c_r5);
            end
            c_r4 <= c_r3;
            c_r5 <= c_r4;
            q_r6   <= q_r5;
            dc_r6  <= dc_r5;
            crs_r6 <= crs_r5;

            res_reg <= res_next;
        end
    end

    assign res = res_reg;

endmodule

// ----- rtl/core/rotate_3d_vector_about_axis_core.sv -----
// Rotates a point about an axis through a pivot by an angle in degrees,
// all in signed Q16.16 by default. The block is a pipeline that takes one
// item per cycle while the output buffer has room. Its depth is set by the
// longer of the axis path (32-stage square root and 31-stage divide) and
// the angle path (angle reduction of K + 1 bits, K = 7 at 16 fraction bits,
// and the CORDIC chain), followed by the rotation stage. A two-item output
// buffer lets the pipeline keep taking items while a result waits; when it
// is full the whole pipeline holds. A zero axis passes the point through
// with zero_axis set, and clipped coordinates raise saturated.
module rotate_3d_vector_about_axis_core #(
    parameter int FRACTION_BITS = rot3d_pkg::FRACTION_BITS_DEF,
    parameter int CORDIC_STEPS  = rot3d_pkg::CORDIC_STEPS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // point_x, point_y, point_z, axis_x, axis_y, axis_z, angle_deg,
    // anchor_x, anchor_y, anchor_z
    input  logic [319:0] s_tdata,
    // axis_present
    input  logic [0:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_x, out_y, out_z
    output logic [95:0]  m_tdata,
    // zero_axis, saturated
    output logic [1:0]   m_tuser
);

    localparam int AX_LAT = rot3d_pkg::AX_LAT;
    localparam int SC_LAT = rot3d_pkg::sc_latency(FRACTION_BITS, CORDIC_STEPS);
    localparam int L      = (AX_LAT > SC_LAT) ? AX_LAT : SC_LAT;
    localparam int TOT    = L + rot3d_pkg::ROT_LAT;

    logic               en;
    logic               push;
    logic               pop;
    logic               vld_reg [TOT];
    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    rot3d_pkg::res_t    buf_reg [2];

    logic signed [31:0] pt_d [3];
    logic signed [31:0] anc_d [3];
    logic [191:0]       pa_in;
    logic [191:0]       pa_d;
    rot3d_pkg::axis_t   axis_u;
    rot3d_pkg::axis_t   axis_d;
    rot3d_pkg::cs_t     cs_u;
    rot3d_pkg::cs_t     cs_d;
    rot3d_pkg::res_t    res;
    rot3d_pkg::res_t    head;

    // The pipeline moves whenever the output buffer has room.
    assign en       = (cnt_reg != 2'd2);
    assign s_tready = en;
    assign push     = en && vld_reg[TOT-1];
    assign pop      = m_tvalid && m_tready;

    assign pa_in     = {s_tdata[319:224], s_tdata[95:0]};

    rot3d_axis_norm u_axis (
        .clk          (clk),
        .en           (en),
        .axis_x       (s_tdata[127:96]),
        .axis_y       (s_tdata[159:128]),
        .axis_z       (s_tdata[191:160]),
        .axis_present (s_tuser[0]),
        .axis         (axis_u)
    );

    rot3d_sincos #(
        .FRACTION_BITS (FRACTION_BITS),
        .CORDIC_STEPS  (CORDIC_STEPS)
    ) u_sincos (
        .clk       (clk),
        .en        (en),
        .angle_deg (s_tdata[223:192]),
        .cs        (cs_u)
    );

    // Align the point, axis and angle paths.
    rot3d_delay #(.WIDTH(192), .DEPTH(L)) u_pa_dly (
        .clk  (clk),
        .en   (en),
        .din  (pa_in),
        .dout (pa_d)
    );

    rot3d_delay #(.WIDTH($bits(rot3d_pkg::axis_t)), .DEPTH(L - AX_LAT)) u_ax_dly (
        .clk  (clk),
        .en   (en),
        .din  (axis_u),
        .dout (axis_d)
    );

    rot3d_delay #(.WIDTH($bits(rot3d_pkg::cs_t)), .DEPTH(L - SC_LAT)) u_cs_dly (
        .clk  (clk),
        .en   (en),
        .din  (cs_u),
        .dout (cs_d)
    );

    assign pt_d[0]  = pa_d[31:0];
    assign pt_d[1]  = pa_d[63:32];
    assign pt_d[2]  = pa_d[95:64];
    assign anc_d[0] = pa_d[127:96];
    assign anc_d[1] = pa_d[159:128];
    assign anc_d[2] = pa_d[191:160];

    rot3d_rotate u_rot (
        .clk    (clk),
        .en     (en),
        .point  (pt_d),
        .anchor (anc_d),
        .axis   (axis_d),
        .cs     (cs_d),
        .res    (res)
    );

    // Valid bits travel with the items.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < TOT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // Two-item output buffer.
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (!push && pop) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop) rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            buf_reg[wr_ptr_reg] <= res;
        end
    end

    assign head     = buf_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != 2'd0);
    assign m_tdata  = {head.z, head.y, head.x};
    assign m_tuser  = {head.sat, head.zero};

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (cnt_reg != 2'd2))
        else $error("result pushed into a full output buffer");

    a_zero_not_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("zero axis result marked saturated");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg[TOT-1]))
        else $error("pipeline moved while stalled");
`endif

endmodule

// ----- sim/tb_rotate_3d_vector_about_axis_core.sv -----
`timescale 1ns / 1ps

module tb_rotate_3d_vector_about_axis_core;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [319:0] s_tdata;
    logic [0:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;

    bit stim_done;

    // Rotation predictor and the queue of rotated points still awaited.
    class rotation_scoreboard;
        rot3d_pkg::res_t awaited[$];
        int      errors;
        longint  atan_tab[32];

        function new();
            atan_tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                         16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                         131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                         128, 64, 32, 16, 8, 4, 2, 1, 0};
            errors = 0;
        endfunction

        function longint unsigned mag(longint v);
            return (v < 0) ? longint'(-v) : v;
        endfunction

        // Product of a Q2.30 coefficient and a value, rounded half away from zero.
        function longint mul_q30(longint a, longint b);
            longint unsigned m;
            m = mag(a) * mag(b);
            m = (m + (64'd1 << 29)) >> 30;
            return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
        endfunction

        function longint round_shift(longint v, int s);
            longint unsigned m;
            m = (mag(v) + (64'd1 << (s - 1))) >> s;
            return (v < 0) ? -longint'(m) : longint'(m);
        endfunction

        function longint unsigned isqrt(longint unsigned n);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (n >= res + bitv) begin
                    n = n - (res + bitv);
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function longint clip_one(longint v);
            if (v > longint'(rot3d_pkg::ONE_Q30)) return longint'(rot3d_pkg::ONE_Q30);
            if (v < -longint'(rot3d_pkg::ONE_Q30)) return -longint'(rot3d_pkg::ONE_Q30);
            return v;
        endfunction

        // Reduce the angle, run the CORDIC and fold the quadrant back in.
        function void cos_sin(longint deg, output longint c, output longint s);
            longint full, half, quarter, r, x, y, z, xs, ys;
            bit flip;
            full = longint'(360) << rot3d_pkg::FRACTION_BITS_DEF;
            half = longint'(180) << rot3d_pkg::FRACTION_BITS_DEF;
            quarter = longint'(90) << rot3d_pkg::FRACTION_BITS_DEF;
            flip = 0;
            r = deg % full;
            if (r < 0) r = r + full;
            if (r >= half) r = r - full;
            if (r > quarter) begin
                r = r - half;
                flip = 1;
            end else if (r < -quarter) begin
                r = r + half;
                flip = 1;
            end
            z = round_shift(r * longint'(rot3d_pkg::DEG_TO_RAD_Q32),
                            rot3d_pkg::FRACTION_BITS_DEF + 2);
            x = longint'(rot3d_pkg::INV_GAIN_Q30);
            y = 0;
            for (int i = 0; i < rot3d_pkg::CORDIC_STEPS_DEF && i < 32; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0) begin
                    x = x - ys;
                    y = y + xs;
                    z = z - atan_tab[i];
                end else begin
                    x = x + ys;
                    y = y - xs;
                    z = z + atan_tab[i];
                end
            end
            x = clip_one(x);
            y = clip_one(y);
            c = flip ? -x : x;
            s = flip ? -y : y;
        endfunction

        function logic [31:0] clip_out(longint v, inout bit sat);
            if (v > 64'sd2147483647) begin
                sat = 1;
                v = 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                sat = 1;
                v = -64'sd2147483648;
            end
            return v[31:0];
        endfunction

        // Work out the rotated point for one accepted item.
        function void note_input(logic [319:0] d, logic axis_on);
            longint p[3], a[3], anc[3], dv[3], u[3], cr[3], rv[3];
            longint c, s, dot, q;
            longint unsigned m, sum, len, am;
            int sh;
            bit sat;
            rot3d_pkg::res_t r;
            sat = 0;
            for (int k = 0; k < 3; k++) begin
                p[k] = $signed(d[32*k +: 32]);
                a[k] = $signed(d[96 + 32*k +: 32]);
                anc[k] = $signed(d[224 + 32*k +: 32]);
                dv[k] = p[k] - anc[k];
            end
            if (axis_on) begin
                m = mag(a[0]);
                if (mag(a[1]) > m) m = mag(a[1]);
                if (mag(a[2]) > m) m = mag(a[2]);
                // A zero axis passes the point through.
                if (m == 0) begin
                    r.x = d[31:0];
                    r.y = d[63:32];
                    r.z = d[95:64];
                    r.zero = 1;
                    r.sat = 0;
                    awaited.push_back(r);
                    return;
                end
                sh = 0;
                while ((m << 1) <= 64'h8000_0000) begin
                    m = m << 1;
                    sh++;
                end
                sum = 0;
                for (int k = 0; k < 3; k++) begin
                    am = mag(a[k]) << sh;
                    sum = sum + am * am;
                end
                len = isqrt(sum);
                for (int k = 0; k < 3; k++) begin
                    am = ((mag(a[k]) << sh) << 30) / len;
                    u[k] = (a[k] < 0) ? -longint'(am) : longint'(am);
                end
            end else begin
                u[0] = 0;
                u[1] = 0;
                u[2] = longint'(rot3d_pkg::ONE_Q30);
            end
            cos_sin($signed(d[223:192]), c, s);
            dot = mul_q30(dv[0], u[0]) + mul_q30(dv[1], u[1]) + mul_q30(dv[2], u[2]);
            cr[0] = mul_q30(dv[2], u[1]) - mul_q30(dv[1], u[2]);
            cr[1] = mul_q30(dv[0], u[2]) - mul_q30(dv[2], u[0]);
            cr[2] = mul_q30(dv[1], u[0]) - mul_q30(dv[0], u[1]);
            for (int k = 0; k < 3; k++) begin
                q = mul_q30(dot, u[k]);
                rv[k] = q - mul_q30(q, c) + mul_q30(dv[k], c) + mul_q30(cr[k], s) + anc[k];
            end
            r.x = clip_out(rv[0], sat);
            r.y = clip_out(rv[1], sat);
            r.z = clip_out(rv[2], sat);
            r.zero = 0;
            r.sat = sat;
            awaited.push_back(r);
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch on %s: got %0h, expected %0h", what, got, want);
            errors++;
        endtask

        // Compare one result item with the oldest rotated point awaited.
        task check_result(logic [95:0] d, logic [1:0] u);
            rot3d_pkg::res_t w;
            if (awaited.size() == 0) begin
                report("unexpected item", longint'(d[63:0]), 0);
                return;
            end
            w = awaited.pop_front();
            if (d[31:0] !== w.x) report("out_x", d[31:0], w.x);
            if (d[63:32] !== w.y) report("out_y", d[63:32], w.y);
            if (d[95:64] !== w.z) report("out_z", d[95:64], w.z);
            if (u[0] !== w.zero) report("zero_axis", u[0], w.zero);
            if (u[1] !== w.sat) report("saturated", u[1], w.sat);
        endtask
    endclass

    rotation_scoreboard sb;

    rotate_3d_vector_about_axis_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // Idle gap before each item on either side, drawn at random, or none while busy.
    function int draw_gap(bit busy);
        return busy ? 0 : $urandom_range(0, 9);
    endfunction

    // Send one point; it is noted once the block accepts it.
    task send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                    logic [31:0] ax, logic [31:0] ay, logic [31:0] az, logic on,
                    logic [31:0] ang, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                    bit busy);
        int gap;
        gap = draw_gap(busy);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= {cz, cy, cx, ang, az, ay, ax, pz, py, px};
        s_tuser <= on;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_input(s_tdata, s_tuser[0]);
    endtask

    // Random coordinate with a random magnitude range.
    function logic [31:0] rnd_coord();
        int v;
        v = $urandom;
        return v >>> $urandom_range(0, 24);
    endfunction

    initial
    begin
        logic [31:0] ax, ay, az, ang;
        logic        on;
        bit          busy;
        int          kind;
        sb = new();
        stim_done = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed items: quadrants, fold points, default axis, zero axis, extremes.
        send_point(32'h10000, 0, 0, 0, 0, 0, 0, 32'h5A0000, 0, 0, 0, 0);
        send_point(32'h10000, 32'h20000, 32'h30000, 0, 0, 0, 0, 32'hB40000, 0, 0, 0, 0);
        send_point(32'h10000, 32'h20000, 0, 0, 0, 0, 0, 32'h10E0000, 0, 0, 0, 0);
        send_point(32'h10000, 0, 0, 0, 0, 0, 0, 32'hFFA60000, 0, 0, 0, 0);
        send_point(32'h10000, 0, 0, 0, 0, 0, 0, 32'hFF4C0000, 0, 0, 0, 0);
        send_point(32'h10000, 0, 0, 0, 0, 0, 0, 32'h1680000, 0, 0, 0, 0);
        send_point(32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 32'h10000, 1,
                   32'h780000, 0, 0, 0, 0);
        send_point(32'h12345, 32'h6789, 32'h1111, 0, 0, 0, 1, 32'h2D0000, 0, 0, 0, 0);
        send_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 1,
                   32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
        send_point(32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0, 0, 1, 1, 32'h2D0000, 0, 0, 0, 0);
        send_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                   32'h7FFFFFFF, 1, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
                   32'h7FFFFFFF, 0);
        send_point(32'h7FFFFFFF, 0, 0, 32'h80000000, 0, 0, 1, 32'h5A0000,
                   32'h80000000, 0, 0, 0);
        send_point(32'h30000, 32'h40000, 32'h50000, 32'h80000000, 32'h80000000,
                   32'h80000000, 1, 32'hFFFFFFFF, 32'h10000, 32'h10000, 32'h10000, 0);
        send_point(32'h30000, 32'h40000, 32'h50000, 1, 0, 0, 1, 1, 0, 0, 0, 0);
        send_point(32'h30000, 32'h40000, 32'h50000, 0, 32'hFFFFFFFF, 0, 1, 32'h5A0001,
                   32'h7FFFFFFF, 32'h80000000, 0, 0);
        send_point(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                   32'hFFFFFFFF, 1, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                   32'hFFFFFFFF, 0);
        send_point(0, 0, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 1, 32'hB40000,
                   32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 0);
        send_point(32'h50000, 0, 0, 0, 0, 0, 0, 32'hFF4BFFFF, 0, 0, 0, 0);

        // Random items, mostly moderate magnitudes with some full-range noise.
        busy = 0;
        for (int n = 0; n < 2000; n++) begin
            if ($urandom_range(0, 99) == 0) busy = ~busy;
            kind = $urandom_range(0, 9);
            on = (kind != 9);
            ax = rnd_coord();
            ay = rnd_coord();
            az = rnd_coord();
            if (kind == 8) begin
                ax = 0;
                ay = 0;
                az = 0;
            end else if (kind == 7) begin
                ax = ($urandom_range(0, 1) != 0) ? ax : 0;
                ay = ($urandom_range(0, 1) != 0) ? ay : 0;
            end
            ang = ($urandom_range(0, 3) == 0) ? $urandom : rnd_coord();
            if (kind <= 2) begin
                send_point($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           1'($urandom_range(0, 1)), $urandom, $urandom, $urandom,
                           $urandom, busy);
            end else begin
                send_point(rnd_coord(), rnd_coord(), rnd_coord(), ax, ay, az, on, ang,
                           rnd_coord(), rnd_coord(), rnd_coord(), busy);
            end
        end
        s_tvalid <= 0;
        stim_done = 1;
    end

    // Result side: random stalls, check each accepted item.
    initial
    begin
        int gap;
        bit busy;
        m_tready = 0;
        busy = 0;
        @(posedge clk iff rst_n);
        forever begin
            if ($urandom_range(0, 99) == 0) busy = ~busy;
            gap = draw_gap(busy);
            if (gap > 0) begin
                m_tready <= 0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
            sb.check_result(m_tdata, m_tuser);
        end
    end

    initial
    begin
        wait (stim_done);
        while (sb.awaited.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard limit well beyond the slowest correct run.
    initial
    begin
        #5ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
